// ----- sv/tqe_pkg.sv -----
package tqe_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int TIME_W         = 64;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // opcodes
  localparam logic [1:0] OP_ARM     = 2'd0;
  localparam logic [1:0] OP_CANCEL  = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;
  localparam logic [1:0] OP_SETWALL = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_FIRE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [3:0]        slot_id;
    logic              absolute_mode;
    logic [TIME_W-1:0] time_value;
    logic [TIME_W-1:0] reload_interval;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [3:0]        fired_slot;
    logic              was_active;
    logic [7:0]        missed_count;
    logic [TIME_W-1:0] wall_time;
    logic              last_result;
  } rsp_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

// ----- sv/tqe_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tqe_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [tqe_pkg::TIME_W-1:0] num,
  input  logic [tqe_pkg::TIME_W-1:0] den,
  output logic                     fin,
  output logic [tqe_pkg::TIME_W-1:0] quo,
  output logic [tqe_pkg::TIME_W-1:0] rem
);
  import tqe_pkg::*;

  localparam int CW = $clog2(TIME_W);

  logic [CW-1:0]     cnt;
  logic              run;
  logic [TIME_W-1:0] dvs;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   trial;

  assign shifted = {rem, quo[TIME_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    fin <= 1'b0;
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (go) begin
      run <= 1'b1;
      cnt <= '0;
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (run) begin
      if (!trial[TIME_W]) begin
        rem <= trial[TIME_W-1:0];
        quo <= {quo[TIME_W-2:0], 1'b1};
      end else begin
        rem <= shifted[TIME_W-1:0];
        quo <= {quo[TIME_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == CW'(TIME_W - 1)) begin
        run <= 1'b0;
        fin <= 1'b1;
      end
    end
  end

endmodule

// ----- sv/timer_queue_engine.sv -----
// Channel  | Handshake            | Payload        | Notes
// command  | start & !busy        | cmd (cmd_t)    | one beat per command
// result   | done (one cycle)     | result (rsp_t) | 1..SLOT_COUNT+1 beats, last_result
//
// Arm and cancel complete in S_IDLE; the ack beat appears the cycle after accept.
// A scan pass examines each slot in S_SCAN and then decides in S_PICK; a firing
// is a pass plus S_FIRE, plus a wait in S_DIV on the shared divider for each
// periodic firing. A time command runs one firing per fired slot plus one empty
// pass per group (two for advance, one for set wall time) plus divides.
// Reset (rst, synchronous) clears active flags, clocks and arm sequence.
// The receiver cannot stall: each result beat is valid for exactly one cycle.
module timer_queue_engine #(
  parameter int SLOT_COUNT = tqe_pkg::SLOT_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tqe_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output tqe_pkg::rsp_t result
);
  import tqe_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_PICK = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIRE = 5'b10000
  } state_t;

  // slot store
  logic [TIME_W-1:0] deadline [SLOT_COUNT];
  logic [TIME_W-1:0] interval [SLOT_COUNT];
  logic              absflag  [SLOT_COUNT];
  logic [15:0]       order    [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] active;

  logic [TIME_W-1:0] wall;
  logic [TIME_W-1:0] elapsed;
  logic [15:0]       arm_seq;

  // sequencer
  state_t            state;
  logic              group;      // 0 delay slots, 1 absolute slots
  logic [IW-1:0]     idx;
  logic              found;
  logic [IW-1:0]     best;
  logic [TIME_W-1:0] best_dl;
  logic [TIME_W-1:0] best_iv;
  logic [15:0]       best_ord;
  logic [SLOT_COUNT-1:0] fired;
  logic [TIME_W-1:0] base;       // deadline + n * interval
  logic [7:0]        missed;
  logic              div_go;

  logic [TIME_W-1:0] now;
  logic              cand;
  logic              better;
  logic [IW-1:0]     sidx;
  logic              svalid;
  logic              div_fin;
  logic [TIME_W-1:0] div_quo;
  logic [TIME_W-1:0] div_rem;

  assign now    = group ? wall : elapsed;
  assign sidx   = IW'(cmd.slot_id);
  assign svalid = (32'(cmd.slot_id) < SLOT_COUNT);
  assign busy   = (state != S_IDLE);

  // one slot is examined per scan cycle
  assign cand = active[idx] && (absflag[idx] == group) && !fired[idx] &&
                (deadline[idx] <= now);
  assign better = !found || (deadline[idx] < best_dl) ||
                  ((deadline[idx] == best_dl) && (order[idx] < best_ord));

  tqe_div u_div (
    .clk (clk),
    .rst (rst),
    .go  (div_go),
    .num (now - best_dl),
    .den (best_iv),
    .fin (div_fin),
    .quo (div_quo),
    .rem (div_rem)
  );

  always_ff @(posedge clk) begin
    done   <= 1'b0;
    div_go <= 1'b0;
    if (rst) begin
      state   <= S_IDLE;
      active  <= '0;
      wall    <= '0;
      elapsed <= '0;
      arm_seq <= '0;
      group   <= 1'b0;
      found   <= 1'b0;
      idx     <= '0;
      fired   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            result.fired_slot   <= cmd.slot_id;
            result.was_active   <= 1'b0;
            result.missed_count <= '0;
            result.wall_time    <= wall;
            result.last_result  <= 1'b1;
            result.result_kind  <= KIND_ACK;
            fired <= '0;
            found <= 1'b0;
            idx   <= '0;
            unique case (cmd.opcode)
              OP_ARM: begin
                done <= 1'b1;
                if (svalid) begin
                  absflag[sidx]  <= cmd.absolute_mode;
                  deadline[sidx] <= cmd.absolute_mode ? cmd.time_value :
                                    sat_add(elapsed, cmd.time_value);
                  interval[sidx] <= cmd.reload_interval;
                  order[sidx]    <= arm_seq;
                  arm_seq        <= arm_seq + 16'd1;
                  active[sidx]   <= 1'b1;
                end
              end
              OP_CANCEL: begin
                done <= 1'b1;
                if (svalid && active[sidx]) begin
                  result.was_active <= 1'b1;
                  active[sidx]      <= 1'b0;
                end
              end
              OP_ADVANCE: begin
                wall    <= sat_add(wall, cmd.time_value);
                elapsed <= sat_add(elapsed, cmd.time_value);
                group   <= 1'b0;
                state   <= S_SCAN;
              end
              default: begin
                wall  <= cmd.time_value;
                group <= 1'b1;
                state <= S_SCAN;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (cand && better) begin
            found    <= 1'b1;
            best     <= idx;
            best_dl  <= deadline[idx];
            best_iv  <= interval[idx];
            best_ord <= order[idx];
          end
          idx <= idx + 1'b1;
          if (idx == IW'(SLOT_COUNT - 1)) begin
            state <= S_PICK;
          end
        end

        S_PICK: begin
          idx <= '0;
          if (found) begin
            if (best_iv == '0) begin
              missed <= '0;
              state  <= S_FIRE;
            end else begin
              div_go <= 1'b1;
              state  <= S_DIV;
            end
          end else if (!group) begin
            group <= 1'b1;
            state <= S_SCAN;
          end else begin
            result.result_kind  <= KIND_DONE;
            result.fired_slot   <= '0;
            result.was_active   <= 1'b0;
            result.missed_count <= '0;
            result.wall_time    <= wall;
            result.last_result  <= 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end

        S_DIV: begin
          if (div_fin) begin
            base   <= now - div_rem;
            missed <= (div_quo[TIME_W-1:8] != '0) ? 8'hFF : div_quo[7:0];
            state  <= S_FIRE;
          end
        end

        S_FIRE: begin
          if (best_iv == '0) begin
            active[best] <= 1'b0;
          end else begin
            deadline[best] <= sat_add(base, best_iv);
            order[best]    <= arm_seq;
            arm_seq        <= arm_seq + 16'd1;
          end
          fired[best] <= 1'b1;
          found       <= 1'b0;
          result.result_kind  <= KIND_FIRE;
          result.fired_slot   <= 4'(best);
          result.was_active   <= 1'b0;
          result.missed_count <= missed;
          result.wall_time    <= wall;
          result.last_result  <= 1'b0;
          done  <= 1'b1;
          state <= S_SCAN;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
